[hw/rtl/greedy_box_suppression_macros.svh]
// Assertion macros shared by the box suppression RTL
`ifndef GREEDY_BOX_SUPPRESSION_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define GBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define GBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/gbs_pkg.sv]
// Shared types and constants of the greedy box suppression block
`default_nettype none
package gbs_pkg;

	// Defaults of the top level parameters
	localparam int MAX_KEPT_DEF   = 64;
	localparam int MAX_BOXES_DEF  = 4096;
	localparam int COORD_BITS_DEF = 16;

	// Fixed field widths
	localparam int COORD_W = 16;
	localparam int LABEL_W = 8;
	localparam int AREA_W  = 32;
	localparam int POS_W   = 12;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 1;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [IDX_W-1:0] REG_IGNORE    = 1'd1;

	// Register reset values
	localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd29491;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;     // latch the incoming box
		logic start_scan; // compute area, rewind pointer, clear suppress flag
		logic issue;      // read one stored box into the compare pipe
		logic finish;     // store the box if kept and the store is not full, and load the result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic store_empty; // nothing to compare against
		logic scan_last;   // current read is the last stored box
		logic pipe_busy;   // compares still in flight
		logic out_free;    // output register can take a result
	} sts_t;

endpackage
`default_nettype wire

[hw/rtl/gbs_ctrl.sv]
// Sequencing state machine of the box suppression block
`default_nettype none
`include "greedy_box_suppression_macros.svh"
module gbs_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              in_ready,
	input  gbs_pkg::sts_t     sts,
	output gbs_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_AREA   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.accept     = s_tvalid && in_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_AREA;
			end
			ST_AREA: begin
				cmd.start_scan = 1'b1;
				state_d = sts.store_empty ? ST_DRAIN : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	`GBS_ASSERT_IMP(a_finish_free, cmd.finish, sts.out_free, "finish without output space")
	`GBS_ASSERT_NXT(a_accept_area, s_tvalid && in_ready, state_q == ST_AREA, "accept did not start")
	`GBS_ASSERT_IMP(a_finish_drained, cmd.finish, !sts.pipe_busy, "finish with compares in flight")

endmodule
`default_nettype wire

[hw/rtl/gbs_dp.sv]
// Datapath: kept-box store, overlap compare pipe, counters and result register
`default_nettype none
`include "greedy_box_suppression_macros.svh"
module gbs_dp #(
	parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
	parameter int MAX_BOXES  = gbs_pkg::MAX_BOXES_DEF,
	parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [gbs_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [gbs_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic [71:0]                 s_tdata,
	input  wire logic [0:0]                  s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [15:0]                      m_tdata,
	output logic [1:0]                       m_tuser,
	input  gbs_pkg::cmd_t                    cmd,
	output gbs_pkg::sts_t                    sts
);

	localparam int CW    = gbs_pkg::COORD_W;
	localparam int LW    = gbs_pkg::LABEL_W;
	localparam int ARW   = gbs_pkg::AREA_W;
	localparam int EW    = (COORD_BITS < CW) ? COORD_BITS : CW;
	localparam logic [CW-1:0] CMASK = CW'((17'(1) << EW) - 17'(1));
	localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int TW    = $clog2(MAX_KEPT + 1);
	localparam int CNT_W = $clog2(MAX_BOXES);
	localparam int PW    = (CNT_W > gbs_pkg::POS_W) ? CNT_W : gbs_pkg::POS_W;
	localparam int ENT_W = ARW + LW + 4 * CW;

	// Configuration registers
	logic [gbs_pkg::CFG_W-1:0] thr_q;
	logic                      ignore_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= gbs_pkg::THRESHOLD_RST;
			ignore_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == gbs_pkg::REG_THRESHOLD) thr_q <= cfg_data;
			if (cfg_index == gbs_pkg::REG_IGNORE) ignore_q <= cfg_data[0];
		end
	end

	// Current box
	logic [CW-1:0]  x0_q, y0_q, x1_q, y1_q;
	logic [LW-1:0]  label_q;
	logic [ARW-1:0] area_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x0_q    <= s_tdata[15:0] & CMASK;
			y0_q    <= s_tdata[31:16] & CMASK;
			x1_q    <= s_tdata[47:32] & CMASK;
			y1_q    <= s_tdata[63:48] & CMASK;
			label_q <= s_tdata[71:64];
		end
	end

	// Box area from its spans
	logic [CW-1:0] w_box, h_box;
	assign w_box = (x1_q > x0_q) ? x1_q - x0_q : '0;
	assign h_box = (y1_q > y0_q) ? y1_q - y0_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.start_scan) area_q <= ARW'(w_box) * ARW'(h_box);
	end

	// Frame counters
	logic [TW-1:0]    total_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_base;
	logic             full;
	logic             supp_q;

	assign cnt_base = s_tuser[0] ? '0 : cnt_q;
	assign full     = (total_q == TW'(MAX_KEPT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.accept) begin
			if (s_tuser[0]) total_q <= '0;
			if (cnt_base < CNT_W'(MAX_BOXES - 1)) cnt_q <= cnt_base + CNT_W'(1);
			else                                  cnt_q <= cnt_base;
		end else if (cmd.finish && !supp_q && !full) begin
			total_q <= total_q + TW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) pos_q <= cnt_base;
	end

	// Kept-box store
	logic [ENT_W-1:0] store_mem [MAX_KEPT];
	logic [AW-1:0]    rd_ptr_q;
	logic [ENT_W-1:0] ent_s1;
	logic             v_s1;

	always_ff @(posedge clk) begin
		if (cmd.finish && !supp_q && !full)
			store_mem[total_q[AW-1:0]] <= {area_q, label_q, y1_q, x1_q, y0_q, x0_q};
		if (cmd.issue) ent_s1 <= store_mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)             rd_ptr_q <= '0;
		else if (cmd.start_scan) rd_ptr_q <= '0;
		else if (cmd.issue)      rd_ptr_q <= rd_ptr_q + AW'(1);
	end

	// Stage 2: intersection extents and label match
	logic [CW-1:0]  kx0, ky0, kx1, ky1;
	logic [LW-1:0]  klabel;
	logic [CW-1:0]  ix_lo, ix_hi, iy_lo, iy_hi;
	logic [CW-1:0]  iw_s2, ih_s2;
	logic [ARW-1:0] karea_s2;
	logic           v_s2;

	assign kx0    = ent_s1[CW-1:0];
	assign ky0    = ent_s1[2*CW-1:CW];
	assign kx1    = ent_s1[3*CW-1:2*CW];
	assign ky1    = ent_s1[4*CW-1:3*CW];
	assign klabel = ent_s1[4*CW+LW-1:4*CW];
	assign ix_lo  = (x0_q > kx0) ? x0_q : kx0;
	assign ix_hi  = (x1_q < kx1) ? x1_q : kx1;
	assign iy_lo  = (y0_q > ky0) ? y0_q : ky0;
	assign iy_hi  = (y1_q < ky1) ? y1_q : ky1;

	always_ff @(posedge clk) begin
		iw_s2    <= (ix_hi > ix_lo) ? ix_hi - ix_lo : '0;
		ih_s2    <= (iy_hi > iy_lo) ? iy_hi - iy_lo : '0;
		karea_s2 <= ent_s1[ENT_W-1:4*CW+LW];
	end

	// Stage 3: intersection area and area sum
	logic [ARW-1:0] inter_s3;
	logic [ARW:0]   sum_s3;
	logic           v_s3;

	always_ff @(posedge clk) begin
		inter_s3 <= ARW'(iw_s2) * ARW'(ih_s2);
		sum_s3   <= {1'b0, area_q} + {1'b0, karea_s2};
	end

	// Stage 4: union
	logic [ARW-1:0] inter_s4;
	logic [ARW:0]   uni_s4;
	logic           v_s4;

	always_ff @(posedge clk) begin
		inter_s4 <= inter_s3;
		uni_s4   <= sum_s3 - {1'b0, inter_s3};
	end

	// Stage 5: scaled intersection against threshold times union
	logic [ARW+15:0] lhs_s5;
	logic [ARW+16:0] rhs_s5;
	logic            v_s5;

	always_ff @(posedge clk) begin
		lhs_s5 <= {inter_s4, 16'd0};
		rhs_s5 <= (ARW+17)'(thr_q) * (ARW+17)'(uni_s4);
	end

	// Valid chain; a label mismatch drops the compare unless labels are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1 && (ignore_q || (klabel == label_q));
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Suppress flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                                    supp_q <= 1'b0;
		else if (cmd.start_scan)                        supp_q <= 1'b0;
		else if (v_s5 && ({1'b0, lhs_s5} > rhs_s5))     supp_q <= 1'b1;
	end

	// Result register
	logic [PW-1:0]  pos_ext;
	logic           out_valid_q;
	logic [15:0]    out_data_q;
	logic [1:0]     out_user_q;

	assign pos_ext = PW'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            out_valid_q <= 1'b0;
		else if (cmd.finish)    out_valid_q <= 1'b1;
		else if (m_tready)      out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= 16'((pos_ext > PW'(4095)) ? PW'(4095) : pos_ext);
			out_user_q <= {!supp_q && full, !supp_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_data_q[11:0]};
	assign m_tuser  = out_user_q;

	// Status
	assign sts.store_empty = (total_q == '0);
	assign sts.scan_last   = ((TW'(rd_ptr_q) + TW'(1)) == total_q);
	assign sts.pipe_busy   = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign sts.out_free    = !out_valid_q || m_tready;

	`GBS_ASSERT_IMP(a_total_max, 1'b1, total_q <= TW'(MAX_KEPT), "kept count beyond store depth")

endmodule
`default_nettype wire

[hw/rtl/greedy_box_suppression.sv]
// Steps: accept, area, one read per stored box, five compare stages, store.
// The kept count is at most MAX_KEPT, and each stored box is read through the single read port
// of the kept-box store; one item is in work at a time.
// The result register frees the input side while a result waits to be taken.
// arst_n clears control, counters and registers (threshold 29491, labels compared).
// Stored boxes are not cleared; only entries below the kept count are ever read.
`default_nettype none
module greedy_box_suppression #(
	parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
	parameter int MAX_BOXES  = gbs_pkg::MAX_BOXES_DEF,
	parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [gbs_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [gbs_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// left_edge, top_edge, right_edge, bottom_edge, class_label
	input  wire logic [71:0]               s_tdata,
	// first_box
	input  wire logic [0:0]                s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// box_position, zero fill
	output logic [15:0]                    m_tdata,
	// kept, store_overflow
	output logic [1:0]                     m_tuser
);

	gbs_pkg::cmd_t cmd;
	gbs_pkg::sts_t sts;

	gbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gbs_dp #(
		.MAX_KEPT   (MAX_KEPT),
		.MAX_BOXES  (MAX_BOXES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire
